// File: hdl/pair_count_hash_table_macros.svh
// ----------------------------------------------------------------------------
// Pair count hash table assertion macros
// Shorthand for the clocked, reset-qualified properties used by the checker.
// ----------------------------------------------------------------------------
`ifndef PAIR_COUNT_HASH_TABLE_MACROS_SVH
`define PAIR_COUNT_HASH_TABLE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PCHT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pair_count_hash_table: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define PCHT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pair_count_hash_table: next-cycle check failed");

`endif

// File: hdl/pcht_pkg.sv
// ----------------------------------------------------------------------------
// Pair count hash table package
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package pcht_pkg;

    localparam int SLOTS_DEF  = 1024;
    localparam int ID_W       = 32;
    localparam int KEY_W      = 2 * ID_W;
    localparam int CNT_W      = 32;
    localparam int HALF_W     = KEY_W / 2;
    localparam int FMIX_SHIFT = 33;

    localparam logic [KEY_W-1:0] FMIX_C1 = 64'hff51afd7ed558ccd;
    localparam logic [KEY_W-1:0] FMIX_C2 = 64'hc4ceb9fe1a85ec53;

    typedef enum logic {
        OP_ADD    = 1'b0,
        OP_LOOKUP = 1'b1
    } pcht_op_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MIX1,
        ST_ADD1,
        ST_MIX2,
        ST_ADD2,
        ST_SEED,
        ST_PROBE,
        ST_RESULT
    } pcht_state_t;

    typedef struct packed {
        logic clear;
        logic load_item;
        logic mix;
        logic mix_c2;
        logic add;
        logic seed;
        logic probe;
        logic out_load;
    } pcht_cmd_t;

    typedef struct packed {
        logic key_zero;
        logic clr_last;
        logic resolve;
        logic out_free;
    } pcht_sts_t;

endpackage

// File: hdl/pcht_ctrl.sv
// ----------------------------------------------------------------------------
// Pair count hash table controller
// Sequences key clearing, the two-round hash mix, probing and result handoff.
// ----------------------------------------------------------------------------
module pcht_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  pcht_pkg::pcht_sts_t sts,
    output pcht_pkg::pcht_cmd_t cmd
);
    import pcht_pkg::*;

    pcht_state_t state_reg;
    pcht_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (sts.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                // a zero key is never stored: skip straight to the empty result
                if (s_valid) begin
                    state_next = sts.key_zero ? ST_RESULT : ST_MIX1;
                end
            end
            ST_MIX1:  state_next = ST_ADD1;
            ST_ADD1:  state_next = ST_MIX2;
            ST_MIX2:  state_next = ST_ADD2;
            ST_ADD2:  state_next = ST_SEED;
            ST_SEED:  state_next = ST_PROBE;
            ST_PROBE: begin
                if (sts.resolve) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_comb begin
        cmd       = '0;
        s_ready   = 1'b0;
        case (state_reg)
            ST_CLEAR:  cmd.clear = 1'b1;
            ST_IDLE: begin
                s_ready       = 1'b1;
                cmd.load_item = s_valid;
            end
            ST_MIX1:   cmd.mix = 1'b1;
            ST_ADD1:   cmd.add = 1'b1;
            ST_MIX2: begin
                cmd.mix    = 1'b1;
                cmd.mix_c2 = 1'b1;
            end
            ST_ADD2:   cmd.add = 1'b1;
            ST_SEED:   cmd.seed = 1'b1;
            ST_PROBE:  cmd.probe = 1'b1;
            ST_RESULT: cmd.out_load = sts.out_free;
            default:   cmd = '0;
        endcase
    end

endmodule

// File: hdl/pcht_dpath.sv
// ----------------------------------------------------------------------------
// Pair count hash table datapath
// Key and count memories, split 64-bit hash multiplier, probe logic, output.
// ----------------------------------------------------------------------------
module pcht_dpath #(
    parameter int SLOTS = pcht_pkg::SLOTS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  pcht_pkg::pcht_cmd_t               cmd,
    output pcht_pkg::pcht_sts_t               sts,
    input  logic                              s_operation,
    input  logic        [pcht_pkg::ID_W-1:0]  s_word_id,
    input  logic        [pcht_pkg::ID_W-1:0]  s_account_id,
    input  logic signed [pcht_pkg::CNT_W-1:0] s_delta,
    input  logic                              m_ready,
    output logic                              m_valid,
    output logic signed [pcht_pkg::CNT_W-1:0] m_pair_count,
    output logic                              m_found,
    output logic                              m_table_full
);
    import pcht_pkg::*;

    localparam int ADDR_W = $clog2(SLOTS);
    localparam int OCC_W  = ADDR_W + 1;
    localparam logic [OCC_W-1:0] HALF_OCC = OCC_W'(SLOTS / 2);

    logic [KEY_W-1:0] key_mem [SLOTS];
    logic [CNT_W-1:0] cnt_mem [SLOTS];

    pcht_op_t          op_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [CNT_W-1:0]  delta_reg;
    logic [KEY_W-1:0]  x_reg;
    logic [KEY_W-1:0]  x_next;
    logic [KEY_W-1:0]  p_ll_reg;
    logic [HALF_W-1:0] p_hl_reg;
    logic [HALF_W-1:0] p_lh_reg;
    logic [ADDR_W-1:0] pos_reg;
    logic [ADDR_W-1:0] pos_next;
    logic [ADDR_W-1:0] steps_reg;
    logic [ADDR_W-1:0] clr_reg;
    logic [OCC_W-1:0]  occ_reg;
    logic [KEY_W-1:0]  key_rd_reg;
    logic [CNT_W-1:0]  cnt_rd_reg;
    logic [CNT_W-1:0]  res_count_reg;
    logic              res_found_reg;
    logic              res_full_reg;
    logic              m_valid_reg;
    logic [CNT_W-1:0]  m_count_reg;
    logic              m_found_reg;
    logic              m_full_reg;

    logic [KEY_W-1:0]  in_key;
    logic [KEY_W-1:0]  x_mix;
    logic [KEY_W-1:0]  mul_c;
    logic [KEY_W-1:0]  p_ll;
    logic [HALF_W-1:0] p_hl;
    logic [HALF_W-1:0] p_lh;
    logic [KEY_W-1:0]  x_sum;
    logic              hit;
    logic              empty;
    logic              step_last;
    logic              resolve;
    logic              full_cond;
    logic [CNT_W-1:0]  sum_count;
    logic              do_update;
    logic              do_insert;
    logic              do_full;
    logic              key_we;
    logic [ADDR_W-1:0] key_waddr;
    logic [KEY_W-1:0]  key_wdata;
    logic              cnt_we;
    logic [CNT_W-1:0]  cnt_wdata;

    assign in_key = {s_word_id, s_account_id};

    // shift-xor, then one round of v * C split into 32-bit partial products
    assign x_mix = x_reg ^ (x_reg >> FMIX_SHIFT);
    assign mul_c = cmd.mix_c2 ? FMIX_C2 : FMIX_C1;
    assign p_ll  = KEY_W'(x_mix[HALF_W-1:0]) * KEY_W'(mul_c[HALF_W-1:0]);
    assign p_hl  = x_mix[KEY_W-1:HALF_W] * mul_c[HALF_W-1:0];
    assign p_lh  = x_mix[HALF_W-1:0] * mul_c[KEY_W-1:HALF_W];
    assign x_sum = p_ll_reg + {HALF_W'(p_hl_reg + p_lh_reg), {HALF_W{1'b0}}};

    always_comb begin
        x_next = x_reg;
        if (cmd.load_item) begin
            x_next = in_key;
        end else if (cmd.add) begin
            x_next = x_sum;
        end
    end

    assign hit       = (key_rd_reg == key_reg);
    assign empty     = (key_rd_reg == '0);
    assign step_last = &steps_reg;
    assign resolve   = hit || empty || step_last;
    assign full_cond = (occ_reg >= HALF_OCC);
    assign sum_count = cnt_rd_reg + delta_reg;

    assign do_update = cmd.probe && hit && (op_reg == OP_ADD);
    assign do_insert = cmd.probe && !hit && empty && (op_reg == OP_ADD) && !full_cond;
    assign do_full   = cmd.probe && resolve && !hit && (op_reg == OP_ADD)
                       && (full_cond || !empty);

    assign key_we    = cmd.clear || do_insert;
    assign key_waddr = cmd.clear ? clr_reg : pos_reg;
    assign key_wdata = cmd.clear ? '0 : key_reg;
    assign cnt_we    = do_update || do_insert;
    assign cnt_wdata = do_update ? sum_count : delta_reg;

    // read address runs one step ahead so read data lines up with pos_reg
    always_comb begin
        pos_next = pos_reg;
        if (cmd.seed) begin
            pos_next = x_mix[ADDR_W-1:0];
        end else if (cmd.probe && !resolve) begin
            pos_next = pos_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_mem[key_waddr] <= key_wdata;
        end
        key_rd_reg <= key_mem[pos_next];
    end

    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            cnt_mem[pos_reg] <= cnt_wdata;
        end
        cnt_rd_reg <= cnt_mem[pos_next];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg     <= '0;
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.clear) begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (do_insert) begin
                occ_reg <= occ_reg + 1'b1;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        x_reg   <= x_next;
        pos_reg <= pos_next;
        if (cmd.load_item) begin
            op_reg    <= pcht_op_t'(s_operation);
            key_reg   <= in_key;
            delta_reg <= s_delta;
        end
        if (cmd.mix) begin
            p_ll_reg <= p_ll;
            p_hl_reg <= p_hl;
            p_lh_reg <= p_lh;
        end
        if (cmd.seed) begin
            steps_reg <= '0;
        end else if (cmd.probe) begin
            steps_reg <= steps_reg + 1'b1;
        end
        if (cmd.load_item) begin
            res_count_reg <= '0;
            res_found_reg <= 1'b0;
            res_full_reg  <= 1'b0;
        end else if (cmd.probe && resolve) begin
            case (op_reg)
                OP_LOOKUP: begin
                    if (hit) begin
                        res_count_reg <= cnt_rd_reg;
                        res_found_reg <= 1'b1;
                    end
                end
                OP_ADD: begin
                    if (hit) begin
                        res_count_reg <= sum_count;
                        res_found_reg <= 1'b1;
                    end else if (do_full) begin
                        res_full_reg <= 1'b1;
                    end else begin
                        res_count_reg <= delta_reg;
                    end
                end
                default: res_found_reg <= 1'b0;
            endcase
        end
        if (cmd.out_load) begin
            m_count_reg <= res_count_reg;
            m_found_reg <= res_found_reg;
            m_full_reg  <= res_full_reg;
        end
    end

    assign sts.key_zero = (in_key == '0);
    assign sts.clr_last = &clr_reg;
    assign sts.resolve  = resolve;
    assign sts.out_free = !m_valid_reg || m_ready;

    assign m_valid      = m_valid_reg;
    assign m_pair_count = m_count_reg;
    assign m_found      = m_found_reg;
    assign m_table_full = m_full_reg;

endmodule

// File: hdl/pair_count_hash_table.sv
// ----------------------------------------------------------------------------
// Pair count hash table
// Counting table keyed by a (word id, account id) pair, linear probing.
// ----------------------------------------------------------------------------
// One item is worked at a time. An accepted item passes through the states
// MIX1, ADD1, MIX2, ADD2, SEED and PROBE, and PROBE steps on one slot at a
// time until it resolves and loads the result register; a pair of two zero
// ids goes straight to RESULT. The input opens again in the cycle after the
// result is loaded. A result held by m_ready low holds the next item back
// until it is taken. The hash is two rounds of a 64-bit multiply built from
// 32-bit partial products (a multiply state and an add state each), and
// probing reads one slot of the key memory per cycle. After reset the key
// memory is cleared one slot per cycle, and no item is accepted until that
// ends. A new pair is refused with m_table_full once half the slots are
// used.
module pair_count_hash_table #(
    parameter int SLOTS = pcht_pkg::SLOTS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_operation,
    input  logic        [pcht_pkg::ID_W-1:0]  s_word_id,
    input  logic        [pcht_pkg::ID_W-1:0]  s_account_id,
    input  logic signed [pcht_pkg::CNT_W-1:0] s_delta,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [pcht_pkg::CNT_W-1:0] m_pair_count,
    output logic                              m_found,
    output logic                              m_table_full
);
    import pcht_pkg::*;

    pcht_cmd_t cmd;
    pcht_sts_t sts;

    pcht_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    pcht_dpath #(
        .SLOTS (SLOTS)
    ) u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .s_operation  (s_operation),
        .s_word_id    (s_word_id),
        .s_account_id (s_account_id),
        .s_delta      (s_delta),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_pair_count (m_pair_count),
        .m_found      (m_found),
        .m_table_full (m_table_full)
    );

endmodule

// File: hdl/pcht_checker.sv
// ----------------------------------------------------------------------------
// Pair count hash table checker
// Port-level checks on result consistency and item sequencing.
// ----------------------------------------------------------------------------
`include "pair_count_hash_table_macros.svh"

module pcht_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic signed [pcht_pkg::CNT_W-1:0] m_pair_count,
    input logic                              m_found,
    input logic                              m_table_full
);
    // stalled result transaction must hold
    `PCHT_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_pair_count) && $stable(m_found) && $stable(m_table_full))
    // a refused insert reports no count
    `PCHT_ASSERT_NOW(a_full_empty, aclk, aresetn, m_valid && m_table_full, !m_found && (m_pair_count == 0))
    // a hit is never flagged full
    `PCHT_ASSERT_NOW(a_found_not_full, aclk, aresetn, m_valid && m_found, !m_table_full)
    // one item in flight: input closes right after an accept
    `PCHT_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready)

endmodule

bind pair_count_hash_table pcht_checker u_pcht_checker (.*);
